### hw/rtl/slotted_string_store_top_defines.svh
// Assertion macros for the slotted string store.
// Used by the port checker; expects clk and rst_n in the including scope.
`ifndef SLOTTED_STRING_STORE_TOP_DEFINES_SVH
`define SLOTTED_STRING_STORE_TOP_DEFINES_SVH

// implication or plain property, checked out of reset
`define SSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never hold
`define SSS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### hw/rtl/sss_pkg.sv
// Shared types and constants for the slotted string store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

    localparam int SEG_DEF   = 4096;
    localparam int SLOTS_DEF = 256;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_DEL = 2'd1;
    localparam logic [1:0] MODE_RD  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_PEND  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  byte_value;
        logic [11:0] string_length;
        logic        last;
        logic [7:0]  slot;
        logic [11:0] position;
    } sss_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot_index;
        logic [7:0]  byte_out;
        logic [12:0] used_length;
        logic [8:0]  string_count;
        logic [11:0] max_insert;
    } sss_rsp_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_DEL,
        OP_RD,
        OP_NOP
    } sss_op_t;

    typedef struct packed {
        sss_op_t  op;
        sss_req_t req;
    } sss_qent_t;

    // head of the request queue as seen by the back end
    typedef struct packed {
        logic      valid;
        sss_qent_t ent;
    } sss_q_t;

endpackage

`default_nettype wire

### hw/rtl/sss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/sss_fe.sv
// Front end: takes requests, decodes the mode and queues them (two entries).
// Depends on sss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sss_fe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sss_pkg::sss_req_t req,
    output logic              busy,
    output sss_pkg::sss_q_t   q,
    input  logic              pop
);
    import sss_pkg::*;

    sss_qent_t   ent_reg [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic        push;
    logic        wr_idx;
    sss_op_t     op;

    always_comb
    begin
        case (req.mode)
            MODE_ADD: op = OP_ADD;
            MODE_DEL: op = OP_DEL;
            MODE_RD:  op = OP_RD;
            default:  op = OP_NOP;
        endcase
    end

    assign busy   = (cnt_reg == 2'd2);
    assign push   = start && !busy;
    assign wr_idx = rd_ptr_reg ^ cnt_reg[0];

    assign q.valid = (cnt_reg != 2'd0);
    assign q.ent   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next    = cnt_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_idx] <= '{op: op, req: req};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sss_be.sv
// Back end: executes queued requests against the byte store, slot table and
// free-slot ring; runs ring refill and compaction sweeps. Depends on sss_pkg, sss_ram.
`timescale 1ns / 1ps
`default_nettype none

module sss_be #(
    parameter int SEG_BYTES = sss_pkg::SEG_DEF,
    parameter int SLOTS     = sss_pkg::SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sss_pkg::sss_q_t   q,
    output logic              pop,
    output logic              done,
    output sss_pkg::sss_rsp_t rsp
);
    import sss_pkg::*;

    localparam int OW       = $clog2(SEG_BYTES + 1);
    localparam int PW       = (OW > 12 ? OW : 12) + 1;
    localparam int AW       = $clog2(2 * SEG_BYTES);
    localparam int SW       = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int UW       = $clog2(SLOTS + 1);
    localparam int DW       = UW + 3;
    localparam int RING     = SLOTS / 8;
    localparam int RW       = RING > 1 ? $clog2(RING) : 1;
    localparam int CW       = $clog2(RING + 1);
    localparam int THR_CMP  = SEG_BYTES * 3 / 4;
    localparam int THR_FILL = SLOTS * 7 / 8;

    localparam logic [OW:0]   SEG_O = (OW + 1)'(SEG_BYTES);
    localparam logic [PW-1:0] SEG_P = PW'(SEG_BYTES);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DONE     = 11'b00000000010,
        S_ADD_TERM = 11'b00000000100,
        S_RD_OFS   = 11'b00000001000,
        S_RD_BYTE  = 11'b00000010000,
        S_REFILL   = 11'b00000100000,
        S_CMP_SLOT = 11'b00001000000,
        S_CMP_OFS  = 11'b00010000000,
        S_CMP_CHK  = 11'b00100000000,
        S_CMP_BYTE = 11'b01000000000,
        S_CMP_TERM = 11'b10000000000
    } sss_state_t;

    sss_state_t       state_reg, state_next;
    logic             bank_reg, bank_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SW-1:0]    ring_reg [RING];
    logic [RW-1:0]    head_reg, head_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [OW-1:0]    fs_reg, fs_next;
    logic [UW-1:0]    used_reg, used_next;
    logic [UW-1:0]    dsc_reg, dsc_next;
    logic             aip_reg, aip_next;
    logic             aacc_reg, aacc_next;
    logic [OW-1:0]    wp_reg, wp_next;
    logic [SW-1:0]    scan_reg, scan_next;
    logic [OW-1:0]    len_reg, len_next;
    logic [OW-1:0]    src_reg, src_next;
    logic [1:0]       pst_reg, pst_next;
    logic [SW-1:0]    pslot_reg, pslot_next;
    logic [7:0]       pbyte_reg, pbyte_next;
    logic [11:0]      pos_reg, pos_next;

    logic             ring_we;
    logic [RW-1:0]    ring_widx;
    logic [SW-1:0]    ring_wdata;

    logic             b_we, b_re;
    logic [AW-1:0]    b_waddr, b_raddr;
    logic [7:0]       b_wdata, b_rdata;
    logic             o_we, o_re;
    logic [SW-1:0]    o_waddr, o_raddr;
    logic [OW-1:0]    o_wdata, o_rdata;

    sss_req_t         r;
    logic             add_first, add_acc, wr_ok, slot_ok, cmp_go, scan_last;
    logic [PW-1:0]    add_sum, rd_sum;
    logic [OW-1:0]    wp0, wp1;
    logic [OW:0]      wp0_inc, len_inc;
    logic [AW-1:0]    base, other_base;
    logic [UW-1:0]    used_dec, dsc_inc;
    logic [DW-1:0]    dsc_lim;
    logic [CW:0]      tail_sum;
    logic [RW-1:0]    tail;
    logic [SW-1:0]    slot_idx;
    logic [OW-1:0]    len_term;

    assign r          = q.ent.req;
    assign slot_idx   = SW'(r.slot);
    assign base       = bank_reg ? AW'(SEG_BYTES) : '0;
    assign other_base = bank_reg ? '0 : AW'(SEG_BYTES);

    assign add_first = !aip_reg;
    assign add_sum   = PW'(fs_reg) + PW'(r.string_length);
    assign add_acc   = add_first ? (cnt_reg != '0 && add_sum < SEG_P) : aacc_reg;
    assign wp0       = add_first ? fs_reg : wp_reg;
    assign wp0_inc   = {1'b0, wp0} + (OW + 1)'(1);
    assign wr_ok     = (r.byte_value != 8'd0) && (wp0_inc < SEG_O);
    assign wp1       = wr_ok ? wp0_inc[OW-1:0] : wp0;

    assign slot_ok   = (32'(r.slot) < 32'(SLOTS)) && valid_reg[slot_idx];
    assign used_dec  = (used_reg != '0) ? used_reg - UW'(1) : used_reg;
    // saturate: past SLOTS/5 the compaction threshold is met regardless
    assign dsc_inc   = (dsc_reg == {UW{1'b1}}) ? dsc_reg : dsc_reg + UW'(1);
    // deletes >= used/5  <=>  used <= 5*deletes + 4
    assign dsc_lim   = DW'(dsc_inc) * DW'(5) + DW'(4);
    assign cmp_go    = (32'(fs_reg) > 32'(THR_CMP)) && (DW'(used_dec) <= dsc_lim);

    assign tail_sum  = (CW + 1)'(head_reg) + (CW + 1)'(cnt_reg);
    assign tail      = (tail_sum >= (CW + 1)'(RING)) ?
                       RW'(tail_sum - (CW + 1)'(RING)) : RW'(tail_sum);

    // position is held from the popped request; the queue head has moved on
    assign rd_sum    = PW'(o_rdata) + PW'(pos_reg);
    assign scan_last = (32'(scan_reg) == 32'(SLOTS - 1));
    assign len_inc   = {1'b0, len_reg} + (OW + 1)'(1);
    assign len_term  = (len_reg < OW'(SEG_BYTES)) ? len_inc[OW-1:0] : len_reg;

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        valid_next = valid_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        fs_next    = fs_reg;
        used_next  = used_reg;
        dsc_next   = dsc_reg;
        aip_next   = aip_reg;
        aacc_next  = aacc_reg;
        wp_next    = wp_reg;
        scan_next  = scan_reg;
        len_next   = len_reg;
        src_next   = src_reg;
        pst_next   = pst_reg;
        pslot_next = pslot_reg;
        pbyte_next = pbyte_reg;
        pos_next   = pos_reg;
        ring_we    = 1'b0;
        ring_widx  = tail;
        ring_wdata = slot_idx;
        b_we       = 1'b0;
        b_waddr    = base + AW'(wp0);
        b_wdata    = r.byte_value;
        b_re       = 1'b0;
        b_raddr    = base + AW'(rd_sum);
        o_we       = 1'b0;
        o_waddr    = scan_reg;
        o_wdata    = len_reg;
        o_re       = 1'b0;
        o_raddr    = slot_idx;
        pop        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q.valid)
                begin
                    pop        = 1'b1;
                    pst_next   = ST_OK;
                    pslot_next = '0;
                    pbyte_next = 8'd0;
                    state_next = S_DONE;
                    case (q.ent.op)
                        OP_ADD:
                        begin
                            if (!add_acc)
                            begin
                                aip_next  = !r.last;
                                aacc_next = 1'b0;
                                pst_next  = ST_FULL;
                            end
                            else
                            begin
                                aip_next  = 1'b1;
                                aacc_next = 1'b1;
                                b_we      = wr_ok;
                                wp_next   = wp1;
                                if (!r.last)
                                begin
                                    pst_next = ST_PEND;
                                end
                                else
                                begin
                                    state_next = S_ADD_TERM;
                                end
                            end
                        end
                        OP_DEL:
                        begin
                            aip_next  = 1'b0;
                            aacc_next = 1'b0;
                            if (!slot_ok)
                            begin
                                pst_next = ST_EMPTY;
                            end
                            else
                            begin
                                valid_next[slot_idx] = 1'b0;
                                used_next = used_dec;
                                dsc_next  = dsc_inc;
                                if (32'(cnt_reg) < 32'(RING))
                                begin
                                    ring_we  = 1'b1;
                                    cnt_next = cnt_reg + CW'(1);
                                end
                                if (cmp_go)
                                begin
                                    scan_next  = '0;
                                    len_next   = '0;
                                    state_next = S_CMP_SLOT;
                                end
                            end
                        end
                        OP_RD:
                        begin
                            aip_next  = 1'b0;
                            aacc_next = 1'b0;
                            if (!slot_ok)
                            begin
                                pst_next = ST_EMPTY;
                            end
                            else
                            begin
                                o_re       = 1'b1;
                                pos_next   = r.position;
                                state_next = S_RD_OFS;
                            end
                        end
                        default:
                        begin
                            pst_next = ST_OK;
                        end
                    endcase
                end
            end

            S_ADD_TERM:
            begin
                pslot_next = ring_reg[head_reg];
                head_next  = (32'(head_reg) == 32'(RING - 1)) ? '0 : head_reg + RW'(1);
                cnt_next   = cnt_reg - CW'(1);
                o_we       = 1'b1;
                o_waddr    = ring_reg[head_reg];
                o_wdata    = fs_reg;
                valid_next[ring_reg[head_reg]] = 1'b1;
                used_next  = used_reg + UW'(1);
                b_we       = (wp_reg < OW'(SEG_BYTES));
                b_waddr    = base + AW'(wp_reg);
                b_wdata    = 8'd0;
                fs_next    = wp_reg + OW'(1);
                aip_next   = 1'b0;
                aacc_next  = 1'b0;
                pst_next   = ST_OK;
                state_next = S_DONE;
                if (cnt_reg == CW'(1) && 32'(used_reg) + 1 < THR_FILL)
                begin
                    head_next  = '0;
                    cnt_next   = '0;
                    used_next  = '0;
                    scan_next  = '0;
                    state_next = S_REFILL;
                end
            end

            S_REFILL:
            begin
                if (valid_reg[scan_reg])
                begin
                    used_next = used_reg + UW'(1);
                end
                else if (32'(cnt_reg) < 32'(RING))
                begin
                    ring_we    = 1'b1;
                    ring_widx  = cnt_reg[RW-1:0];
                    ring_wdata = scan_reg;
                    cnt_next   = cnt_reg + CW'(1);
                end
                if (scan_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + SW'(1);
                end
            end

            S_RD_OFS:
            begin
                if (rd_sum < SEG_P)
                begin
                    b_re       = 1'b1;
                    state_next = S_RD_BYTE;
                end
                else
                begin
                    pbyte_next = 8'd0;
                    state_next = S_DONE;
                end
            end

            S_RD_BYTE:
            begin
                pbyte_next = b_rdata;
                state_next = S_DONE;
            end

            S_CMP_SLOT:
            begin
                o_raddr = scan_reg;
                if (valid_reg[scan_reg])
                begin
                    o_re       = 1'b1;
                    state_next = S_CMP_OFS;
                end
                else if (scan_last)
                begin
                    bank_next  = !bank_reg;
                    fs_next    = len_reg;
                    dsc_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + SW'(1);
                end
            end

            S_CMP_OFS:
            begin
                o_we       = 1'b1;
                src_next   = o_rdata;
                state_next = S_CMP_CHK;
            end

            S_CMP_CHK:
            begin
                b_raddr = base + AW'(src_reg);
                if (src_reg < OW'(SEG_BYTES) && len_inc < SEG_O)
                begin
                    b_re       = 1'b1;
                    state_next = S_CMP_BYTE;
                end
                else
                begin
                    state_next = S_CMP_TERM;
                end
            end

            S_CMP_BYTE:
            begin
                b_waddr = other_base + AW'(len_reg);
                b_wdata = b_rdata;
                if (b_rdata != 8'd0)
                begin
                    b_we       = 1'b1;
                    len_next   = len_inc[OW-1:0];
                    src_next   = src_reg + OW'(1);
                    state_next = S_CMP_CHK;
                end
                else
                begin
                    state_next = S_CMP_TERM;
                end
            end

            S_CMP_TERM:
            begin
                b_waddr  = other_base + AW'(len_reg);
                b_wdata  = 8'd0;
                b_we     = (len_reg < OW'(SEG_BYTES));
                len_next = len_term;
                if (scan_last)
                begin
                    bank_next  = !bank_reg;
                    fs_next    = len_term;
                    dsc_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next  = scan_reg + SW'(1);
                    state_next = S_CMP_SLOT;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bank_reg  <= 1'b0;
            valid_reg <= '0;
            for (int i = 0; i < RING; i++)
            begin
                ring_reg[i] <= SW'(i);
            end
            head_reg  <= '0;
            cnt_reg   <= CW'(RING);
            fs_reg    <= '0;
            used_reg  <= '0;
            dsc_reg   <= '0;
            aip_reg   <= 1'b0;
            aacc_reg  <= 1'b0;
            wp_reg    <= '0;
            scan_reg  <= '0;
            len_reg   <= '0;
            src_reg   <= '0;
            pst_reg   <= ST_OK;
            pslot_reg <= '0;
            pbyte_reg <= 8'd0;
            pos_reg   <= 12'd0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            valid_reg <= valid_next;
            if (ring_we)
            begin
                ring_reg[ring_widx] <= ring_wdata;
            end
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            fs_reg    <= fs_next;
            used_reg  <= used_next;
            dsc_reg   <= dsc_next;
            aip_reg   <= aip_next;
            aacc_reg  <= aacc_next;
            wp_reg    <= wp_next;
            scan_reg  <= scan_next;
            len_reg   <= len_next;
            src_reg   <= src_next;
            pst_reg   <= pst_next;
            pslot_reg <= pslot_next;
            pbyte_reg <= pbyte_next;
            pos_reg   <= pos_next;
        end
    end

    sss_ram #(.WIDTH(8), .DEPTH(2 * SEG_BYTES)) u_byte_ram (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (b_wdata),
        .rd_en   (b_re),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

    sss_ram #(.WIDTH(OW), .DEPTH(SLOTS)) u_ofs_ram (
        .clk     (clk),
        .wr_en   (o_we),
        .wr_addr (o_waddr),
        .wr_data (o_wdata),
        .rd_en   (o_re),
        .rd_addr (o_raddr),
        .rd_data (o_rdata)
    );

    assign done             = (state_reg == S_DONE);
    assign rsp.status       = pst_reg;
    assign rsp.slot_index   = 8'(pslot_reg);
    assign rsp.byte_out     = pbyte_reg;
    assign rsp.used_length  = 13'(fs_reg);
    assign rsp.string_count = 9'(used_reg);
    assign rsp.max_insert   = (cnt_reg != '0 && fs_reg < OW'(SEG_BYTES)) ?
                              12'(OW'(SEG_BYTES - 1) - fs_reg) : 12'd0;

endmodule

`default_nettype wire

### hw/rtl/slotted_string_store_top.sv
// Channel   Handshake           Payload
// request   start / busy        req  (sss_req_t)
// result    done (strobe)       rsp  (sss_rsp_t)
//
// In the back end a read does a slot table read, then a byte store read, which it skips past
// the end. A final add that empties the ring while fewer than SLOTS*7/8 strings are live adds
// a refill sweep over all SLOTS slots. A compacting delete adds a sweep over all SLOTS slots
// that copies every live string byte by byte.
// busy rises when the two-entry request queue is full. Reset is asynchronous.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module slotted_string_store_top #(
    parameter int SEG_BYTES = sss_pkg::SEG_DEF,
    parameter int SLOTS     = sss_pkg::SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sss_pkg::sss_req_t req,
    output logic              done,
    output sss_pkg::sss_rsp_t rsp
);
    import sss_pkg::*;

    sss_q_t q;
    logic   pop;

    sss_fe u_fe (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .q     (q),
        .pop   (pop)
    );

    sss_be #(.SEG_BYTES(SEG_BYTES), .SLOTS(SLOTS)) u_be (
        .clk   (clk),
        .rst_n (rst_n),
        .q     (q),
        .pop   (pop),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

### hw/rtl/sss_chk.sv
// Port-level checker for the slotted string store, bound to the top level.
// Depends on sss_pkg and slotted_string_store_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "slotted_string_store_top_defines.svh"

module sss_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input sss_pkg::sss_rsp_t rsp
);
    import sss_pkg::*;

    // every request ends in a one-cycle result followed by an idle cycle
    `SSS_ASSERT(a_done_gap, done |=> !done, "back-to-back result strobes")

    // the queue only fills through an accepted request
    `SSS_ASSERT(a_busy_rise, $rose(busy) |-> $past(start && !busy), "busy rose without a request")

    `SSS_NEVER(a_byte_ok, done && rsp.byte_out != 8'd0 && rsp.status != ST_OK, "byte on failed request")

endmodule

bind slotted_string_store_top sss_chk u_chk (.*);

`default_nettype wire

### verif/slotted_string_store_top_tb.sv
// Self-checking testbench for slotted_string_store_top: directed requests, then random
// add/delete/read/no-op traffic with random idle gaps, checked by an in-order scoreboard.
// Depends on sss_pkg and slotted_string_store_top.
`timescale 1ns / 1ps

class sss_scoreboard;
    localparam int SEG   = 4096;
    localparam int NSLOT = 256;
    localparam int RING  = NSLOT / 8;

    bit [7:0]    mem [2*SEG];
    bit          written [2*SEG];
    bit          bank;
    int unsigned offs [NSLOT];
    bit          live [NSLOT];
    int unsigned ring [RING];
    int unsigned head, rcount, fstart, nused, ndel, wptr;
    bit          adding, add_ok;
    int unsigned last_slot;
    sss_pkg::sss_rsp_t expq [$];
    int          errors;

    function new();
        for (int i = 0; i < RING; i++)
            ring[i] = i;
        rcount = RING;
    endfunction

    function sss_pkg::sss_rsp_t summary(logic [1:0] st, int unsigned si, int unsigned bo);
        sss_pkg::sss_rsp_t r;
        r.status       = st;
        r.slot_index   = si[7:0];
        r.byte_out     = bo[7:0];
        r.used_length  = fstart[12:0];
        r.string_count = nused[8:0];
        r.max_insert   = (rcount > 0 && fstart < SEG) ? 12'(SEG - fstart - 1) : 12'd0;
        return r;
    endfunction

    function void refill();
        head = 0;
        rcount = 0;
        nused = 0;
        for (int i = 0; i < NSLOT; i++)
            if (live[i])
                nused++;
            else if (rcount < RING)
                ring[rcount++] = i;
    endfunction

    function void compact();
        int unsigned src_b, dst_b, len, src;
        src_b = bank ? SEG : 0;
        dst_b = bank ? 0 : SEG;
        len = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (!live[i])
                continue;
            src = offs[i];
            offs[i] = len;
            while (src < SEG && len + 1 < SEG && mem[src_b + src] != 0)
            begin
                mem[dst_b + len] = mem[src_b + src];
                written[dst_b + len] = 1;
                len++;
                src++;
            end
            if (len < SEG)
            begin
                mem[dst_b + len] = 0;
                written[dst_b + len] = 1;
                len++;
            end
        end
        bank = !bank;
        fstart = len;
        ndel = 0;
    endfunction

    function void note_request(sss_pkg::sss_req_t r);
        int unsigned base, addr, b;
        base = bank ? SEG : 0;
        if (r.mode == 2'd3)
        begin
            expq.push_back(summary(sss_pkg::ST_OK, 0, 0));
            return;
        end
        if (r.mode == sss_pkg::MODE_ADD)
        begin
            if (!adding)
            begin
                adding = 1;
                add_ok = rcount > 0 && fstart + r.string_length < SEG;
                wptr = fstart;
            end
            if (!add_ok)
            begin
                if (r.last)
                    adding = 0;
                expq.push_back(summary(sss_pkg::ST_FULL, 0, 0));
                return;
            end
            if (r.byte_value != 0 && wptr + 1 < SEG)
            begin
                mem[base + wptr] = r.byte_value;
                written[base + wptr] = 1;
                wptr++;
            end
            if (!r.last)
            begin
                expq.push_back(summary(sss_pkg::ST_PEND, 0, 0));
                return;
            end
            last_slot = ring[head % RING];
            head = (head + 1) % RING;
            rcount--;
            offs[last_slot] = fstart;
            live[last_slot] = 1;
            nused++;
            if (wptr < SEG)
            begin
                mem[base + wptr] = 0;
                written[base + wptr] = 1;
            end
            fstart = wptr + 1;
            adding = 0;
            add_ok = 0;
            if (rcount == 0 && nused < NSLOT * 7 / 8)
                refill();
            expq.push_back(summary(sss_pkg::ST_OK, last_slot, 0));
            return;
        end
        adding = 0;
        add_ok = 0;
        if (!live[r.slot])
        begin
            expq.push_back(summary(sss_pkg::ST_EMPTY, 0, 0));
            return;
        end
        if (r.mode == sss_pkg::MODE_DEL)
        begin
            live[r.slot] = 0;
            offs[r.slot] = 0;
            if (nused > 0)
                nused--;
            ndel++;
            if (fstart > SEG * 3 / 4 && ndel >= nused / 5)
                compact();
            if (rcount < RING)
            begin
                ring[(head + rcount) % RING] = r.slot;
                rcount++;
            end
            expq.push_back(summary(sss_pkg::ST_OK, 0, 0));
            return;
        end
        addr = offs[r.slot] + r.position;
        b = (addr < SEG) ? mem[base + addr] : 0;
        expq.push_back(summary(sss_pkg::ST_OK, 0, b));
    endfunction

    function void cmp(string name, int unsigned e, int unsigned a);
        if (e != a)
        begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endfunction

    function void check_result(sss_pkg::sss_rsp_t a);
        sss_pkg::sss_rsp_t e;
        if (expq.size() == 0)
        begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        e = expq.pop_front();
        cmp("status", e.status, a.status);
        cmp("slot_index", e.slot_index, a.slot_index);
        cmp("byte_out", e.byte_out, a.byte_out);
        cmp("used_length", e.used_length, a.used_length);
        cmp("string_count", e.string_count, a.string_count);
        cmp("max_insert", e.max_insert, a.max_insert);
    endfunction

    // mostly a live slot, sometimes any handle
    function int unsigned pick_slot();
        int unsigned s;
        if ($urandom_range(0, 9) < 8)
            for (int k = 0; k < 64; k++)
            begin
                s = $urandom_range(0, NSLOT - 1);
                if (live[s])
                    return s;
            end
        return $urandom_range(0, NSLOT - 1);
    endfunction

    // keep reads off store bytes that were never written
    function int unsigned safe_pos(int unsigned s, int unsigned pos);
        int unsigned addr;
        addr = offs[s] + pos;
        if (live[s] && addr < SEG && !written[(bank ? SEG : 0) + addr])
            return 0;
        return pos;
    endfunction
endclass

module slotted_string_store_top_tb;
    import sss_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    sss_req_t req;
    logic     done;
    sss_rsp_t rsp;

    sss_scoreboard sb;
    bit            no_idle;
    int unsigned   n_sent;

    slotted_string_store_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(rsp);
    end

    // called right after a rising edge; returns at the edge that takes the request
    task automatic send(sss_req_t r);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(r);
        n_sent++;
    endtask

    task automatic idle();
        int unsigned n, g;
        n = $urandom_range(0, 99);
        g = (no_idle || n < 60) ? 0 : (n < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic put(logic [1:0] m, int unsigned b, int unsigned len, bit lst,
                       int unsigned s, int unsigned pos);
        sss_req_t r;
        r.mode          = m;
        r.byte_value    = b[7:0];
        r.string_length = len[11:0];
        r.last          = lst;
        r.slot          = s[7:0];
        r.position      = pos[11:0];
        send(r);
        idle();
    endtask

    // n bytes; the final one carries last unless the add is to be abandoned
    task automatic add_string(int unsigned decl, int unsigned n, bit finish);
        int unsigned b;
        for (int i = 0; i < n; i++)
        begin
            b = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 255);
            put(MODE_ADD, b, decl, finish && i == n - 1, $urandom_range(0, 255),
                $urandom_range(0, 4095));
        end
    endtask

    task automatic random_other(logic [1:0] m, int unsigned s, int unsigned pos);
        put(m, $urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 1), s, pos);
    endtask

    initial
    begin
        int unsigned r, n, s, pos, decl, ab;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        no_idle = 0;
        n_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        put(MODE_NOP, 0, 0, 0, 0, 0);
        put(MODE_NOP, 255, 4095, 1, 255, 4095);
        put(MODE_ADD, 0, 0, 1, 0, 0);                 // empty string
        put(MODE_ADD, 8'h41, 2, 0, 0, 0);
        put(MODE_ADD, 8'h42, 2, 1, 0, 0);
        ab = sb.last_slot;
        put(MODE_RD, 0, 0, 0, ab, 0);
        put(MODE_RD, 0, 0, 0, ab, 1);
        put(MODE_RD, 0, 0, 0, ab, 2);                 // terminator
        put(MODE_RD, 0, 0, 0, ab, 4095);              // past segment end
        put(MODE_DEL, 0, 0, 0, 200, 0);               // empty slot
        put(MODE_RD, 0, 0, 0, 255, 7);
        put(MODE_DEL, 0, 0, 0, 0, 0);
        put(MODE_DEL, 0, 0, 0, 0, 0);
        put(MODE_ADD, 8'h78, 5, 0, 0, 0);             // abandoned by the read
        put(MODE_RD, 0, 0, 0, ab, 0);
        put(MODE_ADD, 8'h61, 3, 0, 0, 0);             // zero byte inside
        put(MODE_ADD, 8'h00, 3, 0, 0, 0);
        put(MODE_NOP, 0, 0, 0, 0, 0);                 // pending add survives
        put(MODE_ADD, 8'h62, 3, 1, 0, 0);
        put(MODE_RD, 0, 0, 0, sb.last_slot, 1);
        put(MODE_ADD, 8'hff, 4095, 0, 0, 0);          // rejected on capacity
        put(MODE_ADD, 8'hff, 4095, 1, 0, 0);
        put(MODE_ADD, 8'h01, 4095, 1, 0, 0);

        // random
        while (n_sent < 450)
        begin
            no_idle = ($urandom_range(0, 9) < 2);
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                n = $urandom_range(0, 39);
                if (n == 0)
                    n = $urandom_range(40, 80);
                else if (n < 6)
                    n = $urandom_range(15, 40);
                else
                    n = $urandom_range(1, 12);
                decl = ($urandom_range(0, 9) < 7) ? n - 1 : $urandom_range(0, 4095);
                if ($urandom_range(0, 9) == 0)
                    add_string(decl, (n + 1) / 2, 0);
                else
                    add_string(decl, n, 1);
            end
            else if (r < 62)
                random_other(MODE_DEL, sb.pick_slot(), $urandom_range(0, 4095));
            else if (r < 90)
            begin
                s = sb.pick_slot();
                pos = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20)
                                                 : $urandom_range(0, 4095);
                random_other(MODE_RD, s, sb.safe_pos(s, pos));
            end
            else if (r < 95)
                random_other(MODE_NOP, $urandom_range(0, 255), $urandom_range(0, 4095));
            else
                add_string($urandom_range(0, 4095), 1, $urandom_range(0, 1));
        end

        start <= 1'b0;
        while (sb.expq.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("slotted_string_store_top_tb: done, clean");
        else
            $display("slotted_string_store_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("slotted_string_store_top_tb: done, errors");
        $finish;
    end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sss_pkg.sv
hw/rtl/sss_ram.sv
hw/rtl/sss_fe.sv
hw/rtl/sss_be.sv
hw/rtl/slotted_string_store_top.sv
hw/rtl/sss_chk.sv
verif/slotted_string_store_top_tb.sv
